### hw/rtl/sps_pkg.sv
// sps_pkg: shared constants, status codes and controller state type
// for the segmented prime sieve. no dependencies.
`default_nettype none

package sps_pkg;

	localparam int VALUE_BITS_DEF  = 20;
	localparam int BASE_SLOTS_DEF  = 1026;
	localparam int SEGMENT_LEN_DEF = 64;

	localparam int MAX_RESULTS = 18;
	localparam int COUNT_BITS  = 7;
	localparam int STATUS_BITS = 2;
	localparam int FIRST_PRIME = 2;

	localparam logic [STATUS_BITS-1:0] STATUS_PRIME = STATUS_BITS'(0);
	localparam logic [STATUS_BITS-1:0] STATUS_NONE  = STATUS_BITS'(1);
	localparam logic [STATUS_BITS-1:0] STATUS_BAD   = STATUS_BITS'(2);

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_BAD,
		S_ROOT,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_CROSS,
		S_LOW,
		S_SEGX,
		S_SEG_RD,
		S_SEG_CHK,
		S_FIN
	} state_t;

endpackage

`default_nettype wire

### hw/rtl/sps_isqrt.sv
// sps_isqrt: iterative integer square root, one result bit per cycle.
// depends on sps_pkg for the default value width.
`default_nettype none

module sps_isqrt #(
	parameter int VALUE_BITS = sps_pkg::VALUE_BITS_DEF
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           start,
	input  wire  [VALUE_BITS-1:0]         value,
	output logic                          busy,
	output logic [(VALUE_BITS+1)/2-1:0]   root
);

	localparam int RB = (VALUE_BITS + 1) / 2;
	localparam int OW = 2 * RB;

	logic [OW-1:0] op_q;
	logic [OW-1:0] res_q;
	logic [OW-1:0] one_q;
	logic [OW-1:0] sum;

	assign sum  = res_q + one_q;
	assign busy = |one_q;
	assign root = res_q[RB-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			one_q <= '0;
		end else if (start) begin
			one_q <= OW'(1) << (OW - 2);
		end else if (busy) begin
			one_q <= one_q >> 2;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_q  <= OW'(value);
			res_q <= '0;
		end else if (busy) begin
			if (op_q >= sum) begin
				op_q  <= op_q - sum;
				res_q <= (res_q >> 1) + one_q;
			end else begin
				res_q <= res_q >> 1;
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/sps_rem.sv
// sps_rem: iterative remainder unit, restoring, two dividend bits per cycle.
// depends on sps_pkg for default widths.
`default_nettype none

module sps_rem #(
	parameter int VALUE_BITS = sps_pkg::VALUE_BITS_DEF,
	parameter int DIV_BITS   = $clog2(sps_pkg::BASE_SLOTS_DEF)
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	input  wire  [VALUE_BITS-1:0] dividend,
	input  wire  [DIV_BITS-1:0]   divisor,
	output logic                  busy,
	output logic [DIV_BITS-1:0]   rem
);

	localparam int STEPS = (VALUE_BITS + 1) / 2;
	localparam int PW    = 2 * STEPS;
	localparam int CW    = $clog2(STEPS + 1);

	logic [CW-1:0]       cnt_q;
	logic [PW-1:0]       dvd_q;
	logic [DIV_BITS-1:0] d_q;
	logic [DIV_BITS-1:0] rem_q;
	logic [DIV_BITS:0]   t1;
	logic [DIV_BITS:0]   t2;
	logic [DIV_BITS-1:0] r1;
	logic [DIV_BITS-1:0] r2;

	always_comb begin
		t1 = {rem_q, dvd_q[PW-1]};
		r1 = (t1 >= {1'b0, d_q}) ? DIV_BITS'(t1 - {1'b0, d_q}) : t1[DIV_BITS-1:0];
		t2 = {r1, dvd_q[PW-2]};
		r2 = (t2 >= {1'b0, d_q}) ? DIV_BITS'(t2 - {1'b0, d_q}) : t2[DIV_BITS-1:0];
	end

	assign busy = (cnt_q != '0);
	assign rem  = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(STEPS);
		end else if (busy) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= PW'(dividend);
			d_q   <= divisor;
			rem_q <= '0;
		end else if (busy) begin
			dvd_q <= dvd_q << 2;
			rem_q <= r2;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/segmented_prime_sieve.sv
// segmented_prime_sieve: top level, controller, base and segment bit memories.
// depends on sps_pkg, sps_isqrt and sps_rem.
//
// channel  dir  handshake                 payload
// range    in   range_valid/range_stall   range_start, range_end
// prime    out  prime_valid/prime_stall   prime_value, prime_count, is_last, status
//
// after reset a clearing pass over every base and segment slot runs; no input is taken.
// a rejected range gives a single bad-status result; otherwise the root is computed, each
// base slot below the limit is read, each base prime runs the remainder unit alongside its
// base writes and then marks its multiples in the segment, then each range number is read
// and the last result is sent.
// a stalled result holds, the scan waits only if a second prime needs it.
`default_nettype none

module segmented_prime_sieve #(
	parameter int VALUE_BITS  = sps_pkg::VALUE_BITS_DEF,
	parameter int BASE_SLOTS  = sps_pkg::BASE_SLOTS_DEF,
	parameter int SEGMENT_LEN = sps_pkg::SEGMENT_LEN_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                range_valid,
	output logic                               range_stall,
	input  wire  [VALUE_BITS-1:0]              range_start,
	input  wire  [VALUE_BITS-1:0]              range_end,
	output logic                               prime_valid,
	input  wire                                prime_stall,
	output logic [VALUE_BITS-1:0]              prime_value,
	output logic [sps_pkg::COUNT_BITS-1:0]     prime_count,
	output logic                               is_last,
	output logic [sps_pkg::STATUS_BITS-1:0]    status
);

	import sps_pkg::*;

	localparam int BASE_BITS = $clog2(BASE_SLOTS);
	localparam int LIM_BITS  = $clog2(BASE_SLOTS + 1);
	localparam int SEG_BITS  = $clog2(SEGMENT_LEN);
	localparam int ROOT_BITS = (VALUE_BITS + 1) / 2;
	localparam int RE_BITS   = ROOT_BITS + 2;
	localparam int SQ_BITS   = 2 * BASE_BITS;
	localparam int CLR_DEPTH = (BASE_SLOTS > SEGMENT_LEN) ? BASE_SLOTS : SEGMENT_LEN;
	localparam int CLR_BITS  = $clog2(CLR_DEPTH);
	localparam int LOW_BITS  = ((VALUE_BITS > BASE_BITS) ? VALUE_BITS : BASE_BITS + 1) + 1;
	localparam int DW        = ((VALUE_BITS > 13) ? VALUE_BITS : 13) + 1;

	state_t state_q;
	state_t state_d;

	logic [CLR_BITS-1:0]   clr_q;
	logic [VALUE_BITS-1:0] start_q;
	logic [SEG_BITS-1:0]   span_q;
	logic [LIM_BITS-1:0]   limit_q;
	logic [LIM_BITS-1:0]   i_q;
	logic [SQ_BITS-1:0]    j_q;
	logic [LOW_BITS-1:0]   sj_q;
	logic [SEG_BITS-1:0]   idx_q;
	logic [COUNT_BITS-1:0] n_q;
	logic                  pend_v_q;
	logic [VALUE_BITS-1:0] pend_q;

	logic                   prime_valid_q;
	logic [VALUE_BITS-1:0]  prime_value_q;
	logic [COUNT_BITS-1:0]  prime_count_q;
	logic                   is_last_q;
	logic [STATUS_BITS-1:0] status_q;

	logic base_mem [BASE_SLOTS];
	logic seg_mem [SEGMENT_LEN];
	logic base_rdata_q;
	logic seg_rdata_q;

	logic                 base_re;
	logic [BASE_BITS-1:0] base_raddr;
	logic                 base_we;
	logic [BASE_BITS-1:0] base_waddr;
	logic                 base_wdata;
	logic                 seg_re;
	logic [SEG_BITS-1:0]  seg_raddr;
	logic                 seg_we;
	logic [SEG_BITS-1:0]  seg_waddr;
	logic                 seg_wdata;

	logic                   root_start;
	logic                   root_busy;
	logic [ROOT_BITS-1:0]   root;
	logic                   rem_start;
	logic                   rem_busy;
	logic [BASE_BITS-1:0]   rem;

	logic                   out_ld;
	logic [VALUE_BITS-1:0]  out_value;
	logic [COUNT_BITS-1:0]  out_count;
	logic                   out_last;
	logic [STATUS_BITS-1:0] out_status;

	logic [VALUE_BITS-1:0] diff;
	logic                  bad;
	logic                  accept;
	logic                  out_free;
	logic [RE_BITS-1:0]    root_ext;
	logic [LIM_BITS-1:0]   limit_d;
	logic [LIM_BITS-1:0]   i_next;
	logic                  more_i;
	logic [BASE_BITS-1:0]  iw;
	logic [SQ_BITS-1:0]    sq;
	logic                  base_done;
	logic [BASE_BITS-1:0]  off;
	logic [LOW_BITS-1:0]   first;
	logic [LOW_BITS-1:0]   twoi;
	logic [LOW_BITS-1:0]   sj_d;
	logic                  seg_go;
	logic [VALUE_BITS-1:0] seg_val;
	logic                  cand;
	logic                  hold;
	logic                  seg_last;

	sps_isqrt #(
		.VALUE_BITS(VALUE_BITS)
	) u_isqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.start (root_start),
		.value (range_end),
		.busy  (root_busy),
		.root  (root)
	);

	sps_rem #(
		.VALUE_BITS(VALUE_BITS),
		.DIV_BITS  (BASE_BITS)
	) u_rem (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (rem_start),
		.dividend(start_q),
		.divisor (iw),
		.busy    (rem_busy),
		.rem     (rem)
	);

	// arithmetic shared by the controller
	always_comb begin
		diff     = range_end - range_start;
		bad      = (range_start > range_end) || (DW'(diff) >= DW'(SEGMENT_LEN));
		accept   = range_valid && (state_q == S_IDLE);
		out_free = !prime_valid_q || !prime_stall;

		root_ext = RE_BITS'(root) + RE_BITS'(2);
		limit_d  = (int'(root_ext) > BASE_SLOTS) ? LIM_BITS'(BASE_SLOTS) : LIM_BITS'(root_ext);

		i_next    = i_q + LIM_BITS'(1);
		more_i    = (i_next < limit_q);
		iw        = i_q[BASE_BITS-1:0];
		sq        = SQ_BITS'(iw) * SQ_BITS'(iw);
		base_done = (j_q >= SQ_BITS'(limit_q));

		off   = (rem == '0) ? '0 : iw - rem;
		first = LOW_BITS'(start_q) + LOW_BITS'(off);
		twoi  = LOW_BITS'(iw) << 1;
		sj_d  = (twoi > first) ? twoi - LOW_BITS'(start_q) : LOW_BITS'(off);

		seg_go   = (sj_q <= LOW_BITS'(span_q));
		seg_val  = start_q + VALUE_BITS'(idx_q);
		cand     = !seg_rdata_q && (seg_val >= VALUE_BITS'(FIRST_PRIME)) &&
		           (n_q < COUNT_BITS'(MAX_RESULTS));
		hold     = cand && pend_v_q && !out_free;
		seg_last = (idx_q == span_q);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_INIT: begin
				if (clr_q == CLR_BITS'(CLR_DEPTH - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (range_valid) state_d = bad ? S_BAD : S_ROOT;
			end
			S_BAD: begin
				if (out_free) state_d = S_IDLE;
			end
			S_ROOT: begin
				if (!root_busy) state_d = S_SCAN_RD;
			end
			S_SCAN_RD: begin
				state_d = (i_q < limit_q) ? S_SCAN_CHK : S_SEG_RD;
			end
			S_SCAN_CHK: begin
				if (!base_rdata_q) state_d = S_CROSS;
				else if (!more_i) state_d = S_SEG_RD;
			end
			S_CROSS: begin
				if (base_done && !rem_busy) state_d = S_LOW;
			end
			S_LOW: begin
				state_d = S_SEGX;
			end
			S_SEGX: begin
				if (!seg_go) state_d = S_SCAN_RD;
			end
			S_SEG_RD: begin
				state_d = S_SEG_CHK;
			end
			S_SEG_CHK: begin
				if (!hold) state_d = seg_last ? S_FIN : S_SEG_RD;
			end
			S_FIN: begin
				if (out_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_INIT;
			end
		endcase
	end

	// memory strobes, unit starts and result loads
	always_comb begin
		range_stall = (state_q != S_IDLE);
		base_re     = 1'b0;
		base_raddr  = iw;
		base_we     = 1'b0;
		base_waddr  = iw;
		base_wdata  = 1'b0;
		seg_re      = 1'b0;
		seg_raddr   = idx_q;
		seg_we      = 1'b0;
		seg_waddr   = idx_q;
		seg_wdata   = 1'b0;
		root_start  = 1'b0;
		rem_start   = 1'b0;
		out_ld      = 1'b0;
		out_value   = '0;
		out_count   = '0;
		out_last    = 1'b0;
		out_status  = STATUS_PRIME;
		unique case (state_q)
			S_INIT: begin
				base_we    = (clr_q <= CLR_BITS'(BASE_SLOTS - 1));
				base_waddr = clr_q[BASE_BITS-1:0];
				seg_we     = (clr_q <= CLR_BITS'(SEGMENT_LEN - 1));
				seg_waddr  = clr_q[SEG_BITS-1:0];
			end
			S_IDLE: begin
				root_start = range_valid && !bad;
			end
			S_BAD: begin
				out_ld     = out_free;
				out_last   = 1'b1;
				out_status = STATUS_BAD;
			end
			S_SCAN_RD: begin
				base_re = (i_q < limit_q);
			end
			S_SCAN_CHK: begin
				// entry is consumed, clear it for the next transaction
				base_we = 1'b1;
				if (base_rdata_q) begin
					base_re    = more_i;
					base_raddr = i_next[BASE_BITS-1:0];
				end else begin
					rem_start = 1'b1;
				end
			end
			S_CROSS: begin
				base_we    = !base_done;
				base_waddr = j_q[BASE_BITS-1:0];
				base_wdata = 1'b1;
			end
			S_SEGX: begin
				seg_we    = seg_go;
				seg_waddr = SEG_BITS'(sj_q);
				seg_wdata = 1'b1;
			end
			S_SEG_RD: begin
				seg_re = 1'b1;
			end
			S_SEG_CHK: begin
				seg_we    = 1'b1;
				out_ld    = cand && pend_v_q && out_free;
				out_value = pend_q;
				out_count = n_q;
			end
			S_FIN: begin
				out_ld   = out_free;
				out_last = 1'b1;
				if (pend_v_q) begin
					out_value  = pend_q;
					out_count  = n_q;
					out_status = STATUS_PRIME;
				end else begin
					out_status = STATUS_NONE;
				end
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_INIT;
			clr_q         <= '0;
			prime_valid_q <= 1'b0;
			pend_v_q      <= 1'b0;
			n_q           <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_INIT) clr_q <= clr_q + CLR_BITS'(1);
			if (out_ld) prime_valid_q <= 1'b1;
			else if (!prime_stall) prime_valid_q <= 1'b0;
			if (accept) begin
				pend_v_q <= 1'b0;
				n_q      <= '0;
			end else if (state_q == S_SEG_CHK && !hold && cand) begin
				pend_v_q <= 1'b1;
				n_q      <= n_q + COUNT_BITS'(1);
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			start_q <= range_start;
			span_q  <= SEG_BITS'(diff);
			idx_q   <= '0;
		end
		if (state_q == S_ROOT && !root_busy) begin
			limit_q <= limit_d;
			i_q     <= LIM_BITS'(FIRST_PRIME);
		end
		if (state_q == S_SCAN_CHK) begin
			if (base_rdata_q) begin
				if (more_i) i_q <= i_next;
			end else begin
				j_q <= sq;
			end
		end
		if (state_q == S_CROSS && !base_done) j_q <= j_q + SQ_BITS'(iw);
		if (state_q == S_LOW) sj_q <= sj_d;
		if (state_q == S_SEGX) begin
			if (seg_go) sj_q <= sj_q + LOW_BITS'(iw);
			else i_q <= i_next;
		end
		if (state_q == S_SEG_CHK && !hold) begin
			if (cand) pend_q <= seg_val;
			if (!seg_last) idx_q <= idx_q + SEG_BITS'(1);
		end
		if (out_ld) begin
			prime_value_q <= out_value;
			prime_count_q <= out_count;
			is_last_q     <= out_last;
			status_q      <= out_status;
		end
	end

	// base sieve bits
	always_ff @(posedge clk) begin
		if (base_we) base_mem[base_waddr] <= base_wdata;
		if (base_re) base_rdata_q <= base_mem[base_raddr];
	end

	// segment crossed-off bits
	always_ff @(posedge clk) begin
		if (seg_we) seg_mem[seg_waddr] <= seg_wdata;
		if (seg_re) seg_rdata_q <= seg_mem[seg_raddr];
	end

	assign prime_valid = prime_valid_q;
	assign prime_value = prime_value_q;
	assign prime_count = prime_count_q;
	assign is_last     = is_last_q;
	assign status      = status_q;

endmodule

`default_nettype wire
